@@ rtl/core/tkl_pkg.sv @@
// Package for the top-k score list: shared types and default constants.
// Used by tkl_mem, tkl_ctrl and top_k_score_list_top; depends on nothing.
`timescale 1ns / 1ps

package tkl_pkg;

    localparam int DEFAULT_LIST_DEPTH = 10;
    localparam int KEY_W              = 32;
    localparam int SCORE_W            = 32;
    localparam int RANK_W             = 4;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [SCORE_W-1:0] score;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MERGE,
        ST_EMIT_PRE,
        ST_EMIT,
        ST_EMPTY
    } state_t;

endpackage

@@ rtl/core/tkl_mem.sv @@
// Entry memory for the top-k score list: one write port and one read port.
// The read data is registered. Uses tkl_pkg.
`timescale 1ns / 1ps

module tkl_mem
    import tkl_pkg::*;
#(
    parameter int DEPTH = 2 * DEFAULT_LIST_DEPTH,
    parameter int AW    = $clog2(2 * DEFAULT_LIST_DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem_q [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_q[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_q[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/tkl_ctrl.sv @@
// Sequencer for the top-k score list: merges an admitted update from one bank
// into the other bank, then reads the list out entry by entry. Uses tkl_pkg.
`timescale 1ns / 1ps

module tkl_ctrl
    import tkl_pkg::*;
#(
    parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH,
    parameter int IW         = $clog2(DEFAULT_LIST_DEPTH + 1),
    parameter int AW         = $clog2(2 * DEFAULT_LIST_DEPTH)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               opcode,
    input  logic [KEY_W-1:0]   item_key,
    input  logic [SCORE_W-1:0] item_score,
    output logic               mem_we,
    output logic [AW-1:0]      mem_waddr,
    output entry_t             mem_wdata,
    output logic [AW-1:0]      mem_raddr,
    input  entry_t             mem_rdata,
    output logic               result_strobe,
    output logic               entry_valid,
    output logic [RANK_W-1:0]  entry_rank,
    output logic [KEY_W-1:0]   entry_key,
    output logic [SCORE_W-1:0] entry_score,
    output logic               admitted,
    output logic               last_entry
);

    localparam logic [IW-1:0] DEPTH_C = IW'(LIST_DEPTH);
    localparam logic [IW-1:0] ONE_C   = IW'(1);

    state_t             state_reg, state_next;
    logic               bank_reg, bank_next;
    logic [IW-1:0]      count_reg, count_next;
    logic [SCORE_W-1:0] last_score_reg, last_score_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [SCORE_W-1:0] score_reg, score_next;
    logic               adm_reg, adm_next;
    logic [IW-1:0]      rd_reg, rd_next;
    logic [IW-1:0]      wr_reg, wr_next;
    logic               ins_reg, ins_next;
    logic               room;
    logic [SCORE_W-1:0] threshold;
    logic [IW-1:0]      rd_inc;

    function automatic logic [AW-1:0] mk_addr(input logic b, input logic [IW-1:0] idx);
        logic [AW-1:0] base;
        base = AW'(idx);
        return b ? (base + AW'(LIST_DEPTH)) : base;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bank_reg  <= 1'b0;
            count_reg <= '0;
            adm_reg   <= 1'b0;
            rd_reg    <= '0;
            wr_reg    <= '0;
            ins_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
            count_reg <= count_next;
            adm_reg   <= adm_next;
            rd_reg    <= rd_next;
            wr_reg    <= wr_next;
            ins_reg   <= ins_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_score_reg <= last_score_next;
        key_reg        <= key_next;
        score_reg      <= score_next;
    end

    assign room      = (wr_reg < DEPTH_C);
    assign threshold = (count_reg == DEPTH_C) ? last_score_reg : '0;
    assign rd_inc    = rd_reg + ONE_C;
    assign busy      = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        bank_next       = bank_reg;
        count_next      = count_reg;
        last_score_next = last_score_reg;
        key_next        = key_reg;
        score_next      = score_reg;
        adm_next        = adm_reg;
        rd_next         = rd_reg;
        wr_next         = wr_reg;
        ins_next        = ins_reg;

        mem_we        = 1'b0;
        mem_waddr     = mk_addr(!bank_reg, wr_reg);
        mem_wdata     = '{key: key_reg, score: score_reg};
        mem_raddr     = mk_addr(bank_reg, '0);
        result_strobe = 1'b0;
        entry_valid   = 1'b0;
        entry_rank    = '0;
        entry_key     = '0;
        entry_score   = '0;
        admitted      = adm_reg;
        last_entry    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    key_next   = item_key;
                    score_next = item_score;
                    adm_next   = 1'b0;
                    rd_next    = '0;
                    wr_next    = '0;
                    ins_next   = 1'b0;
                    if (opcode == OP_CLEAR)
                    begin
                        count_next = '0;
                        state_next = ST_EMPTY;
                    end
                    else if (item_score > threshold)
                    begin
                        adm_next   = 1'b1;
                        state_next = ST_MERGE;
                    end
                    else
                    begin
                        state_next = ST_EMIT_PRE;
                    end
                end
            end

            ST_MERGE:
            begin
                if (rd_reg == count_reg)
                begin
                    if (!ins_reg && room)
                    begin
                        mem_we          = 1'b1;
                        last_score_next = score_reg;
                        count_next      = wr_reg + ONE_C;
                    end
                    else
                    begin
                        count_next = wr_reg;
                    end
                    bank_next  = !bank_reg;
                    state_next = ST_EMIT_PRE;
                end
                else if (!ins_reg && (mem_rdata.score <= score_reg))
                begin
                    ins_next  = 1'b1;
                    mem_raddr = mk_addr(bank_reg, rd_reg);
                    if (room)
                    begin
                        mem_we          = 1'b1;
                        last_score_next = score_reg;
                        wr_next         = wr_reg + ONE_C;
                    end
                end
                else
                begin
                    rd_next = rd_inc;
                    if (rd_inc < count_reg)
                    begin
                        mem_raddr = mk_addr(bank_reg, rd_inc);
                    end
                    if ((mem_rdata.key != key_reg) && room)
                    begin
                        mem_we          = 1'b1;
                        mem_wdata       = mem_rdata;
                        last_score_next = mem_rdata.score;
                        wr_next         = wr_reg + ONE_C;
                    end
                end
            end

            ST_EMIT_PRE:
            begin
                rd_next = '0;
                if (count_reg == '0)
                begin
                    state_next = ST_EMPTY;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                result_strobe = 1'b1;
                entry_valid   = 1'b1;
                entry_rank    = RANK_W'(rd_reg);
                entry_key     = mem_rdata.key;
                entry_score   = mem_rdata.score;
                last_entry    = (rd_inc == count_reg);
                if (rd_inc == count_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_next   = rd_inc;
                    mem_raddr = mk_addr(bank_reg, rd_inc);
                end
            end

            ST_EMPTY:
            begin
                result_strobe = 1'b1;
                last_entry    = 1'b1;
                state_next    = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/top_k_score_list_top.sv @@
// Top-k score list: up to LIST_DEPTH key and score pairs in descending score order.
// An update is merged from one bank into the other, one old entry per cycle apart from the
// insertion and the finishing step, then after a read setup state the list is read out
// one entry per cycle; a new item is accepted only once busy falls after the last result.
// Rejected updates and clears skip the merge. Results are one-cycle strobes the receiver
// cannot stall; reset empties the list only.
`timescale 1ns / 1ps

module top_k_score_list_top
    import tkl_pkg::*;
#(
    parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               opcode,
    input  logic [KEY_W-1:0]   item_key,
    input  logic [SCORE_W-1:0] item_score,
    output logic               result_strobe,
    output logic               entry_valid,
    output logic [RANK_W-1:0]  entry_rank,
    output logic [KEY_W-1:0]   entry_key,
    output logic [SCORE_W-1:0] entry_score,
    output logic               admitted,
    output logic               last_entry
);

    localparam int IW = $clog2(LIST_DEPTH + 1);
    localparam int AW = $clog2(2 * LIST_DEPTH);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic [AW-1:0] mem_raddr;
    entry_t        mem_rdata;

    tkl_mem #(
        .DEPTH (2 * LIST_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tkl_ctrl #(
        .LIST_DEPTH (LIST_DEPTH),
        .IW         (IW),
        .AW         (AW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .item_key      (item_key),
        .item_score    (item_score),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata),
        .result_strobe (result_strobe),
        .entry_valid   (entry_valid),
        .entry_rank    (entry_rank),
        .entry_key     (entry_key),
        .entry_score   (entry_score),
        .admitted      (admitted),
        .last_entry    (last_entry)
    );

endmodule
